// ===== rtl/core/ovi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovi_pkg: shared types and constants of the interval overlap index
// Sizes, field widths, operation and status codes, and the entry and walk
// records used by the core; the channel interfaces use only the widths.
// ----------------------------------------------------------------------------
package ovi_pkg;

  localparam int CAPACITY  = 1024;
  localparam int CONTIGS   = 16;
  localparam int MAX_HITS  = 64;

  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int BIG_W     = CNT_W + 1;
  localparam int LVL_W     = $clog2(CNT_W + 1);
  localparam int CTG_W     = 4;
  localparam int CTG_IDX_W = $clog2(CONTIGS);
  localparam int POS_W     = 31;
  localparam int LAB_W     = 32;
  localparam int OP_W      = 3;
  localparam int ST_W      = 3;
  localparam int HIT_W     = $clog2(MAX_HITS + 1);
  localparam int STK_DEPTH = 2 * (CNT_W + 1);
  localparam int SP_W      = $clog2(STK_DEPTH + 1);
  localparam int SI_W      = $clog2(STK_DEPTH);
  localparam int LEAF_LVL  = 3;

  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
  localparam logic [OP_W-1:0] OP_BUILD   = 3'd2;
  localparam logic [OP_W-1:0] OP_OVERLAP = 3'd3;
  localparam logic [OP_W-1:0] OP_CONTAIN = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE   = 3'd0;
  localparam logic [ST_W-1:0] ST_HIT    = 3'd1;
  localparam logic [ST_W-1:0] ST_NOHIT  = 3'd2;
  localparam logic [ST_W-1:0] ST_REJECT = 3'd3;
  localparam logic [ST_W-1:0] ST_NOINDEX = 3'd4;

  typedef struct packed {
    logic [CTG_W-1:0] contig;
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] fin;
    logic [LAB_W-1:0] label;
  } entry_t;

  typedef struct packed {
    logic [BIG_W-1:0] node;
    logic [LVL_W-1:0] lvl;
    logic             phase;
  } walk_t;

endpackage

// ===== rtl/core/ovi_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovi_req_if: request channel of the interval overlap index
// Valid/ready handshake carrying one operation and its interval fields.
// ----------------------------------------------------------------------------
interface ovi_req_if;
  import ovi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [CTG_W-1:0]        contig;
  logic [POS_W-1:0]        start_req;
  logic [POS_W-1:0]        finish;
  logic signed [LAB_W-1:0] label;

  modport source (output valid, operation, contig, start_req, finish, label, input ready);
  modport sink   (input valid, operation, contig, start_req, finish, label, output ready);

endinterface

// ===== rtl/core/ovi_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ovi_rsp_if: result channel of the interval overlap index
// Valid/ready handshake carrying one status or hit record.
// ----------------------------------------------------------------------------
interface ovi_rsp_if;
  import ovi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic [IDX_W-1:0]        hit_index;
  logic [POS_W-1:0]        hit_start;
  logic [POS_W-1:0]        hit_end;
  logic signed [LAB_W-1:0] hit_label;
  logic                    truncated;
  logic                    last;

  modport source (output valid, status, hit_index, hit_start, hit_end, hit_label,
                  truncated, last, input ready);
  modport sink   (input valid, status, hit_index, hit_start, hit_end, hit_label,
                  truncated, last, output ready);

endinterface

// ===== rtl/core/interval_overlap_index.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_overlap_index: sorted interval store with implicit interval tree
// Clear and rejects answer directly from idle; add shifts each larger entry up
// one slot, then writes the new one; build finds the contig runs, then fills
// each contig's subtree max end tree level by level. Queries read one tree node
// or entry at a time (one entry read port), and hold while a result is stalled.
// One request at a time. Reset empties the store; memories are not cleared.
// ----------------------------------------------------------------------------
module interval_overlap_index (
  input logic       clk,
  input logic       rst,
  ovi_req_if.sink   req,
  ovi_rsp_if.source rsp
);
  import ovi_pkg::*;

  typedef enum logic [25:0] {
    S_IDLE     = 26'd1,
    S_RESP     = 26'd1 << 1,
    S_ADD_RD   = 26'd1 << 2,
    S_ADD_CMP  = 26'd1 << 3,
    S_RUN_RD   = 26'd1 << 4,
    S_RUN_CMP  = 26'd1 << 5,
    S_BLD_CTG  = 26'd1 << 6,
    S_BLD_L0RD = 26'd1 << 7,
    S_BLD_L0WR = 26'd1 << 8,
    S_BLD_LVL  = 26'd1 << 9,
    S_BLD_RDL  = 26'd1 << 10,
    S_BLD_RDR  = 26'd1 << 11,
    S_BLD_RDE  = 26'd1 << 12,
    S_BLD_WR   = 26'd1 << 13,
    S_BLD_LRD  = 26'd1 << 14,
    S_BLD_LCMP = 26'd1 << 15,
    S_Q_POP    = 26'd1 << 16,
    S_Q_LEAF   = 26'd1 << 17,
    S_Q_LEAFD  = 26'd1 << 18,
    S_Q_P0     = 26'd1 << 19,
    S_Q_P1     = 26'd1 << 20,
    S_C_BS     = 26'd1 << 21,
    S_C_BSD    = 26'd1 << 22,
    S_C_SCAN   = 26'd1 << 23,
    S_C_SCAND  = 26'd1 << 24,
    S_FIN      = 26'd1 << 25
  } state_t;

  state_t state;

  // Store bookkeeping
  logic [CNT_W-1:0]     cnt;
  logic                 built;
  logic [IDX_W-1:0]     ctg_off  [CONTIGS];
  logic [CNT_W-1:0]     ctg_size [CONTIGS];
  logic [LVL_W-1:0]     ctg_root [CONTIGS];

  // Latched request
  logic [CTG_W-1:0]     r_ctg;
  logic [POS_W-1:0]     r_st;
  logic [POS_W-1:0]     r_en;
  logic [LAB_W-1:0]     r_lab;
  logic [ST_W-1:0]      resp_status;

  // Insert, run scan and build sequencer
  logic [CNT_W-1:0]     pos;
  logic [CNT_W-1:0]     ri;
  logic [CNT_W-1:0]     run_start;
  logic [CTG_W-1:0]     run_ctg;
  logic [CTG_IDX_W-1:0] bc;
  logic [LVL_W-1:0]     k;
  logic [BIG_W-1:0]     bi;
  logic [BIG_W-1:0]     last_i;
  logic [POS_W-1:0]     last_v;
  logic [POS_W-1:0]     el;
  logic [POS_W-1:0]     er;
  logic                 er_mem;

  // Query walk
  logic [CNT_W-1:0]     n;
  logic [IDX_W-1:0]     off;
  walk_t                stk [STK_DEPTH];
  logic [SP_W-1:0]      sp;
  walk_t                cur;
  logic [BIG_W-1:0]     qi;
  logic [BIG_W-1:0]     qend;
  logic [CNT_W-1:0]     lo;
  logic [CNT_W-1:0]     hi;

  // Hit collection
  logic [HIT_W-1:0]     hit_cnt;
  logic                 dropped;
  logic                 pend_v;
  entry_t               pend;
  logic [IDX_W-1:0]     pend_idx;

  // Memories
  entry_t               ent_mem [CAPACITY];
  logic [POS_W-1:0]     smx_mem [CAPACITY];
  entry_t               ent_rd;
  logic [IDX_W-1:0]     ent_ra_q;
  logic [POS_W-1:0]     smx_rd;

  logic                 ent_re, ent_we, smx_re, smx_we;
  logic [IDX_W-1:0]     ent_ra, ent_wa, smx_ra, smx_wa;
  entry_t               ent_wd;
  logic [POS_W-1:0]     smx_wd;

  // Output register
  logic                 ov;
  logic [ST_W-1:0]      o_status;
  logic [IDX_W-1:0]     o_idx;
  entry_t               o_ent;
  logic                 o_trunc;
  logic                 o_last;

  logic                 emit_en;
  logic [ST_W-1:0]      emit_status;
  logic [IDX_W-1:0]     emit_idx;
  entry_t               emit_ent;
  logic                 emit_trunc;
  logic                 emit_last;

  logic                 can_emit;
  logic                 hit_req, hit_drop, hit_stall, hit_ok;

  // Derived values
  logic [SI_W-1:0]      sp_idx, sp_top, sp_nxt;
  walk_t                top;
  logic [BIG_W-1:0]     top_half, top_y, leaf_i0, leaf_i1;
  logic [BIG_W-1:0]     cur_half;
  logic [BIG_W-1:0]     bx;
  logic [BIG_W-1:0]     n_big;
  logic [CNT_W-1:0]     mid;
  logic [POS_W-1:0]     wmax_a, wmax;
  entry_t               new_ent;
  logic                 add_move;

  function automatic logic [IDX_W-1:0] ea(input logic [IDX_W-1:0] o,
                                          input logic [BIG_W-1:0] i);
    return o + i[IDX_W-1:0];
  endfunction

  assign can_emit = !ov || rsp.ready;
  assign req.ready = (state == S_IDLE);

  assign sp_idx   = sp[SI_W-1:0];
  assign sp_top   = SI_W'(sp - 1'b1);
  assign sp_nxt   = SI_W'(sp + 1'b1);
  assign top      = stk[sp_top];
  assign top_half = BIG_W'(1) << (top.lvl - 1'b1);
  assign top_y    = top.node - top_half;
  assign leaf_i0  = (top.node >> top.lvl) << top.lvl;
  assign leaf_i1  = leaf_i0 + (BIG_W'(1) << (top.lvl + 1'b1)) - 1'b1;
  assign cur_half = BIG_W'(1) << (cur.lvl - 1'b1);
  assign bx       = BIG_W'(1) << (k - 1'b1);
  assign n_big    = BIG_W'(n);
  assign mid      = lo + ((hi - lo) >> 1);
  assign wmax_a   = (el > ent_rd.fin) ? el : ent_rd.fin;
  assign wmax     = (er > wmax_a) ? er : wmax_a;
  assign new_ent  = '{contig: r_ctg, start: r_st, fin: r_en, label: r_lab};
  assign add_move = (ent_rd.contig > r_ctg) ||
                    ((ent_rd.contig == r_ctg) && (ent_rd.start > r_st));

  // Entry memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    if (ent_re) begin
      ent_rd   <= ent_mem[ent_ra];
      ent_ra_q <= ent_ra;
    end
  end

  // Subtree max end memory
  always_ff @(posedge clk) begin
    if (smx_we) smx_mem[smx_wa] <= smx_wd;
    if (smx_re) smx_rd <= smx_mem[smx_ra];
  end

  // Memory strobes, hit detection and result selection
  always_comb begin
    ent_re = 1'b0; ent_ra = '0; ent_we = 1'b0; ent_wa = '0; ent_wd = new_ent;
    smx_re = 1'b0; smx_ra = '0; smx_we = 1'b0; smx_wa = '0; smx_wd = '0;
    emit_en = 1'b0; emit_status = ST_DONE; emit_idx = '0; emit_ent = '0;
    emit_trunc = 1'b0; emit_last = 1'b1;
    hit_req = 1'b0;
    case (state)
      S_RESP: begin
        emit_en = can_emit;
        emit_status = resp_status;
      end
      S_ADD_RD: begin
        if (pos == '0) begin
          ent_we = 1'b1;
          ent_wa = '0;
        end else begin
          ent_re = 1'b1;
          ent_ra = IDX_W'(pos - 1'b1);
        end
      end
      S_ADD_CMP: begin
        ent_we = 1'b1;
        ent_wa = pos[IDX_W-1:0];
        ent_wd = add_move ? ent_rd : new_ent;
      end
      S_RUN_RD: begin
        ent_re = (ri < cnt);
        ent_ra = ri[IDX_W-1:0];
      end
      S_BLD_L0RD: begin
        ent_re = (bi < n_big);
        ent_ra = ea(off, bi);
      end
      S_BLD_L0WR: begin
        smx_we = 1'b1;
        smx_wa = ea(off, bi);
        smx_wd = ent_rd.fin;
      end
      S_BLD_RDL: begin
        smx_re = (bi < n_big);
        smx_ra = ea(off, bi - bx);
      end
      S_BLD_RDR: begin
        smx_re = (bi + bx < n_big);
        smx_ra = ea(off, bi + bx);
      end
      S_BLD_RDE: begin
        ent_re = 1'b1;
        ent_ra = ea(off, bi);
      end
      S_BLD_WR: begin
        smx_we = 1'b1;
        smx_wa = ea(off, bi);
        smx_wd = wmax;
      end
      S_BLD_LRD: begin
        smx_re = (last_i < n_big);
        smx_ra = ea(off, last_i);
      end
      S_Q_POP: begin
        if (sp != '0 && top.lvl > LVL_W'(LEAF_LVL)) begin
          if (!top.phase) begin
            smx_re = (top_y < n_big);
            smx_ra = ea(off, top_y);
          end else begin
            ent_re = (top.node < n_big);
            ent_ra = ea(off, top.node);
          end
        end
      end
      S_Q_P1: hit_req = (ent_rd.start < r_en) && (r_st < ent_rd.fin);
      S_Q_LEAF: begin
        ent_re = (qi < qend);
        ent_ra = ea(off, qi);
      end
      S_Q_LEAFD: hit_req = (ent_rd.start < r_en) && (r_st < ent_rd.fin);
      S_C_BS: begin
        ent_re = (hi > lo);
        ent_ra = ea(off, BIG_W'(mid));
      end
      S_C_SCAN: begin
        ent_re = (qi < n_big);
        ent_ra = ea(off, qi);
      end
      S_C_SCAND: hit_req = (ent_rd.start < r_en) && (ent_rd.start >= r_st) &&
                           (ent_rd.fin <= r_en);
      S_FIN: begin
        emit_en = can_emit;
        if (pend_v) begin
          emit_status = ST_HIT;
          emit_idx    = pend_idx;
          emit_ent    = pend;
          emit_trunc  = dropped;
        end else begin
          emit_status = ST_NOHIT;
        end
      end
      default: ;
    endcase

    hit_drop  = hit_req && (hit_cnt == HIT_W'(MAX_HITS));
    hit_stall = hit_req && !hit_drop && pend_v && !can_emit;
    hit_ok    = hit_req && !hit_drop && !hit_stall;

    // Release the held hit once a newer one shows it is not the last
    if (hit_ok && pend_v) begin
      emit_en     = 1'b1;
      emit_status = ST_HIT;
      emit_idx    = pend_idx;
      emit_ent    = pend;
      emit_trunc  = 1'b0;
      emit_last   = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit_en) begin
      ov <= 1'b1;
    end else if (rsp.ready) begin
      ov <= 1'b0;
    end
    if (emit_en) begin
      o_status <= emit_status;
      o_idx    <= emit_idx;
      o_ent    <= emit_ent;
      o_trunc  <= emit_trunc;
      o_last   <= emit_last;
    end
  end

  assign rsp.valid     = ov;
  assign rsp.status    = o_status;
  assign rsp.hit_index = o_idx;
  assign rsp.hit_start = o_ent.start;
  assign rsp.hit_end   = o_ent.fin;
  assign rsp.hit_label = o_ent.label;
  assign rsp.truncated = o_trunc;
  assign rsp.last      = o_last;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      built  <= 1'b0;
      pend_v <= 1'b0;
      sp     <= '0;
      for (int j = 0; j < CONTIGS; j++) begin
        ctg_off[j]  <= '0;
        ctg_size[j] <= '0;
        ctg_root[j] <= '0;
      end
    end else begin
      // Hold the newest hit until the next one or the end of the query
      if (hit_ok) begin
        pend     <= ent_rd;
        pend_idx <= ent_ra_q;
        pend_v   <= 1'b1;
        hit_cnt  <= hit_cnt + 1'b1;
      end
      if (hit_drop) dropped <= 1'b1;

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            r_ctg   <= req.contig;
            r_st    <= req.start_req;
            r_en    <= req.finish;
            r_lab   <= req.label;
            hit_cnt <= '0;
            dropped <= 1'b0;
            pend_v  <= 1'b0;
            case (req.operation)
              OP_CLEAR: begin
                cnt   <= '0;
                built <= 1'b0;
                for (int j = 0; j < CONTIGS; j++) begin
                  ctg_off[j]  <= '0;
                  ctg_size[j] <= '0;
                  ctg_root[j] <= '0;
                end
                resp_status <= ST_DONE;
                state       <= S_RESP;
              end
              OP_ADD: begin
                if (req.start_req > req.finish || cnt == CNT_W'(CAPACITY)) begin
                  resp_status <= ST_REJECT;
                  state       <= S_RESP;
                end else begin
                  pos   <= cnt;
                  built <= 1'b0;
                  state <= S_ADD_RD;
                end
              end
              OP_BUILD: begin
                for (int j = 0; j < CONTIGS; j++) begin
                  ctg_off[j]  <= '0;
                  ctg_size[j] <= '0;
                  ctg_root[j] <= '0;
                end
                ri        <= '0;
                run_start <= '0;
                state     <= S_RUN_RD;
              end
              OP_OVERLAP, OP_CONTAIN: begin
                if (!built) begin
                  resp_status <= ST_NOINDEX;
                  state       <= S_RESP;
                end else begin
                  n   <= ctg_size[req.contig[CTG_IDX_W-1:0]];
                  off <= ctg_off[req.contig[CTG_IDX_W-1:0]];
                  if (ctg_size[req.contig[CTG_IDX_W-1:0]] == '0) begin
                    state <= S_FIN;
                  end else if (req.operation == OP_OVERLAP) begin
                    stk[0] <= '{node: (BIG_W'(1) << ctg_root[req.contig[CTG_IDX_W-1:0]])
                                      - 1'b1,
                                lvl: ctg_root[req.contig[CTG_IDX_W-1:0]],
                                phase: 1'b0};
                    sp    <= SP_W'(1);
                    state <= S_Q_POP;
                  end else begin
                    lo    <= '0;
                    hi    <= ctg_size[req.contig[CTG_IDX_W-1:0]];
                    state <= S_C_BS;
                  end
                end
              end
              default: begin
                resp_status <= ST_REJECT;
                state       <= S_RESP;
              end
            endcase
          end
        end

        S_RESP: begin
          if (can_emit) state <= S_IDLE;
        end

        // Insert: shift larger keys up one slot, then drop the new entry in
        S_ADD_RD: begin
          if (pos == '0) begin
            cnt         <= cnt + 1'b1;
            resp_status <= ST_DONE;
            state       <= S_RESP;
          end else begin
            state <= S_ADD_CMP;
          end
        end
        S_ADD_CMP: begin
          if (add_move) begin
            pos   <= pos - 1'b1;
            state <= S_ADD_RD;
          end else begin
            cnt         <= cnt + 1'b1;
            resp_status <= ST_DONE;
            state       <= S_RESP;
          end
        end

        // Build, first pass: find each contig's run
        S_RUN_RD: begin
          if (ri < cnt) begin
            state <= S_RUN_CMP;
          end else begin
            if (cnt != '0) begin
              ctg_off[run_ctg[CTG_IDX_W-1:0]]  <= run_start[IDX_W-1:0];
              ctg_size[run_ctg[CTG_IDX_W-1:0]] <= cnt - run_start;
            end
            bc    <= '0;
            state <= S_BLD_CTG;
          end
        end
        S_RUN_CMP: begin
          if (ri == '0) begin
            run_ctg <= ent_rd.contig;
          end else if (ent_rd.contig != run_ctg) begin
            ctg_off[run_ctg[CTG_IDX_W-1:0]]  <= run_start[IDX_W-1:0];
            ctg_size[run_ctg[CTG_IDX_W-1:0]] <= ri - run_start;
            run_start <= ri;
            run_ctg   <= ent_rd.contig;
          end
          ri    <= ri + 1'b1;
          state <= S_RUN_RD;
        end

        // Build, second pass: per contig tree
        S_BLD_CTG: begin
          if (ctg_size[bc] == '0) begin
            if (bc == CTG_IDX_W'(CONTIGS - 1)) begin
              built       <= 1'b1;
              resp_status <= ST_DONE;
              state       <= S_RESP;
            end else begin
              bc <= bc + 1'b1;
            end
          end else begin
            n     <= ctg_size[bc];
            off   <= ctg_off[bc];
            bi    <= '0;
            state <= S_BLD_L0RD;
          end
        end
        S_BLD_L0RD: begin
          if (bi < n_big) begin
            state <= S_BLD_L0WR;
          end else begin
            k     <= LVL_W'(1);
            state <= S_BLD_LVL;
          end
        end
        S_BLD_L0WR: begin
          last_v <= ent_rd.fin;
          last_i <= bi;
          bi     <= bi + BIG_W'(2);
          state  <= S_BLD_L0RD;
        end
        S_BLD_LVL: begin
          if ((BIG_W'(1) << k) <= n_big) begin
            bi    <= (bx << 1) - 1'b1;
            state <= S_BLD_RDL;
          end else begin
            ctg_root[bc] <= k - 1'b1;
            if (bc == CTG_IDX_W'(CONTIGS - 1)) begin
              built       <= 1'b1;
              resp_status <= ST_DONE;
              state       <= S_RESP;
            end else begin
              bc    <= bc + 1'b1;
              state <= S_BLD_CTG;
            end
          end
        end
        S_BLD_RDL: begin
          if (bi < n_big) begin
            state <= S_BLD_RDR;
          end else begin
            last_i <= last_i[k] ? last_i - bx : last_i + bx;
            state  <= S_BLD_LRD;
          end
        end
        S_BLD_RDR: begin
          el     <= smx_rd;
          er_mem <= (bi + bx < n_big);
          state  <= S_BLD_RDE;
        end
        S_BLD_RDE: begin
          er    <= er_mem ? smx_rd : last_v;
          state <= S_BLD_WR;
        end
        S_BLD_WR: begin
          bi    <= bi + (bx << 2);
          state <= S_BLD_RDL;
        end
        S_BLD_LRD: begin
          if (last_i < n_big) begin
            state <= S_BLD_LCMP;
          end else begin
            k     <= k + 1'b1;
            state <= S_BLD_LVL;
          end
        end
        S_BLD_LCMP: begin
          if (smx_rd > last_v) last_v <= smx_rd;
          k     <= k + 1'b1;
          state <= S_BLD_LVL;
        end

        // Overlap walk: pop a node and dispatch
        S_Q_POP: begin
          if (sp == '0) begin
            state <= S_FIN;
          end else if (top.lvl <= LVL_W'(LEAF_LVL)) begin
            qi    <= leaf_i0;
            qend  <= (leaf_i1 > n_big) ? n_big : leaf_i1;
            sp    <= sp - 1'b1;
            state <= S_Q_LEAF;
          end else if (!top.phase) begin
            cur <= top;
            if (top_y >= n_big) begin
              stk[sp_top].phase <= 1'b1;
              stk[sp_idx] <= '{node: top_y, lvl: top.lvl - 1'b1, phase: 1'b0};
              sp <= sp + 1'b1;
            end else begin
              sp    <= sp - 1'b1;
              state <= S_Q_P0;
            end
          end else begin
            cur <= top;
            sp  <= sp - 1'b1;
            if (top.node < n_big) state <= S_Q_P1;
          end
        end
        S_Q_P0: begin
          stk[sp_idx] <= '{node: cur.node, lvl: cur.lvl, phase: 1'b1};
          if (smx_rd > r_st) begin
            stk[sp_nxt] <= '{node: cur.node - cur_half, lvl: cur.lvl - 1'b1, phase: 1'b0};
            sp <= sp + SP_W'(2);
          end else begin
            sp <= sp + 1'b1;
          end
          state <= S_Q_POP;
        end
        S_Q_P1: begin
          if (ent_rd.start < r_en) begin
            if (hit_drop) begin
              state <= S_FIN;
            end else if (!hit_stall) begin
              stk[sp_idx] <= '{node: cur.node + cur_half, lvl: cur.lvl - 1'b1,
                                phase: 1'b0};
              sp    <= sp + 1'b1;
              state <= S_Q_POP;
            end
          end else begin
            state <= S_Q_POP;
          end
        end
        S_Q_LEAF: begin
          state <= (qi < qend) ? S_Q_LEAFD : S_Q_POP;
        end
        S_Q_LEAFD: begin
          if (ent_rd.start >= r_en) begin
            state <= S_Q_POP;
          end else if (hit_drop) begin
            state <= S_FIN;
          end else if (!hit_stall) begin
            qi    <= qi + 1'b1;
            state <= S_Q_LEAF;
          end
        end

        // Contain query: binary search the first start, then scan
        S_C_BS: begin
          if (hi > lo) begin
            qi    <= BIG_W'(mid);
            state <= S_C_BSD;
          end else begin
            qi    <= BIG_W'(lo);
            state <= S_C_SCAN;
          end
        end
        S_C_BSD: begin
          if (ent_rd.start >= r_st) hi <= qi[CNT_W-1:0];
          else lo <= CNT_W'(qi + 1'b1);
          state <= S_C_BS;
        end
        S_C_SCAN: begin
          state <= (qi < n_big) ? S_C_SCAND : S_FIN;
        end
        S_C_SCAND: begin
          if (ent_rd.start >= r_en) begin
            state <= S_FIN;
          end else if (hit_drop) begin
            state <= S_FIN;
          end else if (!hit_stall) begin
            qi    <= qi + 1'b1;
            state <= S_C_SCAN;
          end
        end

        // Close the query with the held hit or a no-hit result
        S_FIN: begin
          if (can_emit) begin
            pend_v <= 1'b0;
            state  <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
